// ===== rtl/lobm_pkg.sv =====
// Shared types and constants for the limit order book matcher.
// Used by the channel interfaces, the slot cells, the slot chain and the top level.
package lobm_pkg;

  localparam int ORDER_SLOTS_DEF = 32;
  localparam int PRICE_W = 31;
  localparam int QTY_W   = 32;
  localparam int ID_W    = 32;
  // Wide enough for the sum of up to 64 full quantities
  localparam int AVAIL_W = 38;

  localparam logic [PRICE_W-1:0] PRICE_TOP    = '1;
  localparam logic [PRICE_W-1:0] PRICE_BOTTOM = '0;

  // Request kinds
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;

  // Order types
  localparam logic [2:0] TYPE_LIMIT  = 3'd0;
  localparam logic [2:0] TYPE_MARKET = 3'd1;
  localparam logic [2:0] TYPE_IOC    = 3'd2;
  localparam logic [2:0] TYPE_FOK    = 3'd3;
  localparam logic [2:0] TYPE_POST   = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_TRADE  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_MODIFY = 2'd3;

  // Side
  localparam logic SIDE_BUY = 1'b0;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_FILL,
    CMD_LOAD
  } cmd_e;

  // Search key held steady while a scan runs down the chain
  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] limit;
    logic [ID_W-1:0]    target;
    logic [ID_W-1:0]    nxt;
  } query_t;

  // Write command for one slot
  typedef struct packed {
    cmd_e               op;
    logic               side;
    logic [2:0]         otype;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    id;
  } cmd_t;

  // Running scan record handed from cell to cell
  typedef struct packed {
    logic               best_found;
    logic [PRICE_W-1:0] best_price;
    logic [ID_W-1:0]    best_id;
    logic [QTY_W-1:0]   best_rem;
    logic               free_found;
    logic               tgt_found;
    logic               tgt_side;
    logic [2:0]         tgt_type;
    logic [AVAIL_W-1:0] avail;
  } wave_t;

  // One result word
  typedef struct packed {
    logic [1:0]         result_kind;
    logic               ok;
    logic               found;
    logic [ID_W-1:0]    order_id;
    logic [ID_W-1:0]    rest_id;
    logic [ID_W-1:0]    trade_id;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   trade_qty;
    logic               aggressor;
    logic               last;
  } res_t;

endpackage

// ===== rtl/lobm_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on lobm_pkg for field widths.
interface lobm_req_if import lobm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               side;
  logic [2:0]         order_type;
  logic [PRICE_W-1:0] price;
  logic [QTY_W-1:0]   quantity;
  logic [ID_W-1:0]    target_id;

  modport source (output valid, mode, side, order_type, price, quantity, target_id,
                  input ready);
  modport sink (input valid, mode, side, order_type, price, quantity, target_id,
                output ready);
endinterface

interface lobm_res_if import lobm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic               ok;
  logic               found;
  logic [ID_W-1:0]    order_id;
  logic [ID_W-1:0]    rest_id;
  logic [ID_W-1:0]    trade_id;
  logic [PRICE_W-1:0] trade_price;
  logic [QTY_W-1:0]   trade_qty;
  logic               aggressor;
  logic               last;

  modport source (output valid, result_kind, ok, found, order_id, rest_id, trade_id,
                  trade_price, trade_qty, aggressor, last, input ready);
  modport sink (input valid, result_kind, ok, found, order_id, rest_id, trade_id,
                trade_price, trade_qty, aggressor, last, output ready);
endinterface

// ===== rtl/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: request sequencer and result register.
// Depends on lobm_pkg, lobm_if and lobm_chain.
//
//   channel  dir  modport  word
//   req_i    in   sink     mode, side, order_type, price, quantity, target_id
//   res_o    out  source   result_kind, ok, found, order_id, rest_id, trade_id,
//                          trade_price, trade_qty, aggressor, last
//
// Every book scan walks the slot chain one cell at a time; the sequencer then decides.
// A cancel runs one target scan. An add runs a check scan, then a match scan, and
// rescans after each trade; a modify runs a target scan before the add.
// One request is worked at a time; req_i is ready only when idle.
// Each result word is held in a register until taken, and the sequencer waits there.
// Reset empties the book and sets the order and trade counters to one.
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lobm_req_if.sink    req_i,
  lobm_res_if.source  res_o
);

  localparam int IDX_W = $clog2(ORDER_SLOTS);
  localparam int CNT_W = $clog2(ORDER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SCAN_LEN = CNT_W'(ORDER_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_ADD,
    S_MATCH,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         mode_q, mode_d;
  logic               side_q, side_d;
  logic [2:0]         type_q, type_d;
  logic [PRICE_W-1:0] price_q, price_d;
  logic [PRICE_W-1:0] limit_q, limit_d;
  logic [QTY_W-1:0]   qty_q, qty_d;
  logic [QTY_W-1:0]   rem_q, rem_d;
  logic [ID_W-1:0]    target_q, target_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [ID_W-1:0]    nxt_q, nxt_d;
  logic [ID_W-1:0]    trd_q, trd_d;
  logic               more_q, more_d;
  res_t               out_q, out_d;

  query_t           query;
  cmd_t             cmd;
  logic [IDX_W-1:0] cmd_idx;
  wave_t            wave;
  logic [IDX_W-1:0] best_idx, free_idx, tgt_idx;

  logic             bad, is_mod;
  logic [1:0]       ack_kind;
  logic [QTY_W-1:0] fill;

  function automatic logic [PRICE_W-1:0] limit_of(logic s, logic [2:0] t,
                                                  logic [PRICE_W-1:0] p);
    if (t == TYPE_MARKET) begin
      return (s == SIDE_BUY) ? PRICE_TOP : PRICE_BOTTOM;
    end
    return p;
  endfunction

  assign query = '{side: side_q, limit: limit_q, target: target_q, nxt: nxt_q};

  lobm_chain #(
    .ORDER_SLOTS(ORDER_SLOTS),
    .IDX_W(IDX_W)
  ) u_chain (
    .clk_i,
    .rst_ni,
    .query_i   (query),
    .cmd_i     (cmd),
    .cmd_idx_i (cmd_idx),
    .wave_o    (wave),
    .best_idx_o(best_idx),
    .free_idx_o(free_idx),
    .tgt_idx_o (tgt_idx)
  );

  assign is_mod   = (mode_q == MODE_MODIFY);
  assign ack_kind = is_mod ? KIND_MODIFY : KIND_ADD;
  assign bad      = (type_q > TYPE_POST) || (qty_q == '0) ||
                    ((type_q == TYPE_LIMIT) && (price_q == '0)) || !wave.free_found;
  assign fill     = (rem_q < wave.best_rem) ? rem_q : wave.best_rem;

  // Sequence one request
  always_comb begin
    state_d  = state_q;
    cnt_d    = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    mode_d   = mode_q;
    side_d   = side_q;
    type_d   = type_q;
    price_d  = price_q;
    limit_d  = limit_q;
    qty_d    = qty_q;
    rem_d    = rem_q;
    target_d = target_q;
    id_d     = id_q;
    nxt_d    = nxt_q;
    trd_d    = trd_q;
    more_d   = more_q;
    out_d    = out_q;
    cmd      = '0;
    cmd.op   = CMD_NONE;
    cmd_idx  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d   = req_i.mode;
          side_d   = req_i.side;
          type_d   = req_i.order_type;
          price_d  = req_i.price;
          qty_d    = req_i.quantity;
          target_d = req_i.target_id;
          limit_d  = limit_of(req_i.side, req_i.order_type, req_i.price);
          cnt_d    = SCAN_LEN;
          priority case (req_i.mode)
            MODE_ADD:    state_d = S_ADD;
            MODE_CANCEL: state_d = S_TGT;
            MODE_MODIFY: state_d = S_TGT;
            default:     state_d = S_IDLE;
          endcase
        end
      end

      S_TGT: begin
        if (cnt_q == '0) begin
          if (wave.tgt_found) begin
            cmd.op  = CMD_CLEAR;
            cmd_idx = tgt_idx;
          end
          if (mode_q == MODE_CANCEL || !wave.tgt_found) begin
            out_d = '0;
            out_d.result_kind = (mode_q == MODE_CANCEL) ? KIND_CANCEL : KIND_MODIFY;
            out_d.ok    = (mode_q == MODE_CANCEL) && wave.tgt_found;
            out_d.found = (mode_q == MODE_CANCEL) && wave.tgt_found;
            out_d.last  = 1'b1;
            more_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            // Re-enter as an add with the resting order's side and type
            side_d  = wave.tgt_side;
            type_d  = wave.tgt_type;
            limit_d = limit_of(wave.tgt_side, wave.tgt_type, price_q);
            cnt_d   = SCAN_LEN;
            state_d = S_ADD;
          end
        end
      end

      S_ADD: begin
        if (cnt_q == '0) begin
          out_d = '0;
          out_d.result_kind = ack_kind;
          out_d.found = is_mod;
          out_d.last  = 1'b1;
          more_d = 1'b0;
          if (bad) begin
            state_d = S_OUT;
          end else begin
            id_d  = nxt_q;
            nxt_d = nxt_q + 1'b1;
            if (type_q == TYPE_FOK && wave.avail < AVAIL_W'(qty_q)) begin
              state_d = S_OUT;
            end else if (type_q == TYPE_POST && wave.best_found) begin
              out_d.order_id = nxt_q;
              state_d = S_OUT;
            end else begin
              rem_d   = qty_q;
              cnt_d   = SCAN_LEN;
              state_d = S_MATCH;
            end
          end
        end
      end

      S_MATCH: begin
        if (cnt_q == '0) begin
          out_d = '0;
          if (rem_q != '0 && wave.best_found) begin
            // Fill against the best maker and rescan
            cmd.op  = CMD_FILL;
            cmd.qty = fill;
            cmd_idx = best_idx;
            out_d.result_kind = KIND_TRADE;
            out_d.order_id    = id_q;
            out_d.rest_id     = wave.best_id;
            out_d.trade_id    = trd_q;
            out_d.trade_price = wave.best_price;
            out_d.trade_qty   = fill;
            out_d.aggressor   = side_q;
            trd_d   = trd_q + 1'b1;
            rem_d   = rem_q - fill;
            cnt_d   = SCAN_LEN;
            more_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            if (rem_q != '0 && (type_q == TYPE_LIMIT || type_q == TYPE_POST)) begin
              cmd.op    = CMD_LOAD;
              cmd.side  = side_q;
              cmd.otype = type_q;
              cmd.price = limit_q;
              cmd.qty   = rem_q;
              cmd.id    = id_q;
              cmd_idx   = free_idx;
            end
            out_d.result_kind = ack_kind;
            out_d.ok       = 1'b1;
            out_d.found    = is_mod;
            out_d.order_id = id_q;
            out_d.last     = 1'b1;
            more_d  = 1'b0;
            state_d = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (res_o.ready) begin
          state_d = more_q ? S_MATCH : S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      mode_q   <= MODE_ADD;
      side_q   <= 1'b0;
      type_q   <= TYPE_LIMIT;
      price_q  <= '0;
      limit_q  <= '0;
      qty_q    <= '0;
      rem_q    <= '0;
      target_q <= '0;
      id_q     <= '0;
      nxt_q    <= ID_W'(1);
      trd_q    <= ID_W'(1);
      more_q   <= 1'b0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      mode_q   <= mode_d;
      side_q   <= side_d;
      type_q   <= type_d;
      price_q  <= price_d;
      limit_q  <= limit_d;
      qty_q    <= qty_d;
      rem_q    <= rem_d;
      target_q <= target_d;
      id_q     <= id_d;
      nxt_q    <= nxt_d;
      trd_q    <= trd_d;
      more_q   <= more_d;
      out_q    <= out_d;
    end
  end

  // Drive the channels
  assign req_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = (state_q == S_OUT);
  assign res_o.result_kind = out_q.result_kind;
  assign res_o.ok          = out_q.ok;
  assign res_o.found       = out_q.found;
  assign res_o.order_id    = out_q.order_id;
  assign res_o.rest_id     = out_q.rest_id;
  assign res_o.trade_id    = out_q.trade_id;
  assign res_o.trade_price = out_q.trade_price;
  assign res_o.trade_qty   = out_q.trade_qty;
  assign res_o.aggressor   = out_q.aggressor;
  assign res_o.last        = out_q.last;

endmodule

// ===== rtl/lobm_cell.sv =====
// One resting-order slot plus one stage of the scan chain.
// Depends on lobm_pkg.
module lobm_cell import lobm_pkg::*; #(
  parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
  parameter int IDX_W = $clog2(ORDER_SLOTS),
  parameter logic [IDX_W-1:0] MY_IDX = '0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  query_t           query_i,
  input  cmd_t             cmd_i,
  input  logic [IDX_W-1:0] cmd_idx_i,
  input  wave_t            wave_i,
  input  logic [IDX_W-1:0] best_idx_i,
  input  logic [IDX_W-1:0] free_idx_i,
  input  logic [IDX_W-1:0] tgt_idx_i,
  output wave_t            wave_o,
  output logic [IDX_W-1:0] best_idx_o,
  output logic [IDX_W-1:0] free_idx_o,
  output logic [IDX_W-1:0] tgt_idx_o
);

  logic               valid_q, valid_d;
  logic               side_q;
  logic [2:0]         otype_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   rem_q, rem_d;
  logic [ID_W-1:0]    id_q;
  logic               sel;

  wave_t            wave_d, wave_q;
  logic [IDX_W-1:0] best_idx_d, best_idx_q;
  logic [IDX_W-1:0] free_idx_d, free_idx_q;
  logic [IDX_W-1:0] tgt_idx_d, tgt_idx_q;

  logic            crosses, better;
  logic [ID_W-1:0] age_me, age_best;

  assign sel = (cmd_idx_i == MY_IDX);

  // Apply slot write commands
  always_comb begin
    valid_d = valid_q;
    rem_d   = rem_q;
    if (sel) begin
      unique case (cmd_i.op)
        CMD_CLEAR: valid_d = 1'b0;
        CMD_FILL: begin
          rem_d   = rem_q - cmd_i.qty;
          valid_d = (rem_d != '0);
        end
        CMD_LOAD: begin
          valid_d = 1'b1;
          rem_d   = cmd_i.qty;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (sel && cmd_i.op == CMD_LOAD) begin
      side_q  <= cmd_i.side;
      otype_q <= cmd_i.otype;
      price_q <= cmd_i.price;
      id_q    <= cmd_i.id;
    end
  end

  // Fold this slot into the scan record
  always_comb begin
    crosses = valid_q && (side_q != query_i.side) &&
              ((query_i.side == SIDE_BUY) ? (price_q <= query_i.limit)
                                          : (price_q >= query_i.limit));
    age_me   = query_i.nxt - id_q;
    age_best = query_i.nxt - wave_i.best_id;
    better   = !wave_i.best_found ||
               ((query_i.side == SIDE_BUY) ? (price_q < wave_i.best_price)
                                           : (price_q > wave_i.best_price)) ||
               ((price_q == wave_i.best_price) && (age_me > age_best));

    wave_d     = wave_i;
    best_idx_d = best_idx_i;
    free_idx_d = free_idx_i;
    tgt_idx_d  = tgt_idx_i;
    if (crosses) begin
      wave_d.avail = wave_i.avail + AVAIL_W'(rem_q);
      if (better) begin
        wave_d.best_found = 1'b1;
        wave_d.best_price = price_q;
        wave_d.best_id    = id_q;
        wave_d.best_rem   = rem_q;
        best_idx_d        = MY_IDX;
      end
    end
    if (!wave_i.free_found && !valid_q) begin
      wave_d.free_found = 1'b1;
      free_idx_d        = MY_IDX;
    end
    if (!wave_i.tgt_found && valid_q && (id_q == query_i.target)) begin
      wave_d.tgt_found = 1'b1;
      wave_d.tgt_side  = side_q;
      wave_d.tgt_type  = otype_q;
      tgt_idx_d        = MY_IDX;
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk_i) begin
    wave_q     <= wave_d;
    best_idx_q <= best_idx_d;
    free_idx_q <= free_idx_d;
    tgt_idx_q  <= tgt_idx_d;
  end

  assign wave_o     = wave_q;
  assign best_idx_o = best_idx_q;
  assign free_idx_o = free_idx_q;
  assign tgt_idx_o  = tgt_idx_q;

endmodule

// ===== rtl/lobm_chain.sv =====
// Row of slot cells; the scan record enters empty at slot 0 and leaves after the last.
// Depends on lobm_pkg and lobm_cell.
module lobm_chain import lobm_pkg::*; #(
  parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
  parameter int IDX_W = $clog2(ORDER_SLOTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  query_t           query_i,
  input  cmd_t             cmd_i,
  input  logic [IDX_W-1:0] cmd_idx_i,
  output wave_t            wave_o,
  output logic [IDX_W-1:0] best_idx_o,
  output logic [IDX_W-1:0] free_idx_o,
  output logic [IDX_W-1:0] tgt_idx_o
);

  wave_t            wave [ORDER_SLOTS+1];
  logic [IDX_W-1:0] bidx [ORDER_SLOTS+1];
  logic [IDX_W-1:0] fidx [ORDER_SLOTS+1];
  logic [IDX_W-1:0] tidx [ORDER_SLOTS+1];

  // Start every scan from an empty record
  assign wave[0] = '0;
  assign bidx[0] = '0;
  assign fidx[0] = '0;
  assign tidx[0] = '0;

  for (genvar k = 0; k < ORDER_SLOTS; k++) begin : g_cell
    lobm_cell #(
      .ORDER_SLOTS(ORDER_SLOTS),
      .IDX_W(IDX_W),
      .MY_IDX(IDX_W'(k))
    ) u_cell (
      .clk_i,
      .rst_ni,
      .query_i,
      .cmd_i,
      .cmd_idx_i,
      .wave_i    (wave[k]),
      .best_idx_i(bidx[k]),
      .free_idx_i(fidx[k]),
      .tgt_idx_i (tidx[k]),
      .wave_o    (wave[k+1]),
      .best_idx_o(bidx[k+1]),
      .free_idx_o(fidx[k+1]),
      .tgt_idx_o (tidx[k+1])
    );
  end

  assign wave_o     = wave[ORDER_SLOTS];
  assign best_idx_o = bidx[ORDER_SLOTS];
  assign free_idx_o = fidx[ORDER_SLOTS];
  assign tgt_idx_o  = tidx[ORDER_SLOTS];

endmodule
